// ----- hdl/dma4_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dma4_pkg
// shared types and constants for the four-channel dma engine
// ----------------------------------------------------------------------------
package dma4_pkg;

    localparam int unsigned NUM_CHANNELS = 4;
    localparam int unsigned CHAN_BYTES   = 12;
    localparam int unsigned FILE_BYTES   = NUM_CHANNELS * CHAN_BYTES;

    localparam int unsigned REQ_QUEUE_DEPTH = 4;

    localparam logic [31:0] ADDR_MASK   = 32'h0FFF_FFFF;
    localparam logic [31:0] FIFO_A_ADDR = 32'h0400_00A0;
    localparam logic [31:0] FIFO_B_ADDR = 32'h0400_00A4;
    localparam logic [13:0] CNT_MASK    = 14'h3FFF;
    localparam logic [16:0] CNT_FULL    = 17'h0_4000;
    localparam logic [16:0] CNT_FULL_CH3 = 17'h1_0000;

    // byte positions inside one channel block
    localparam logic [3:0] BYTE_CNT_LO  = 4'd8;
    localparam logic [3:0] BYTE_CNT_HI  = 4'd9;
    localparam logic [3:0] BYTE_CTRL_LO = 4'd10;
    localparam logic [3:0] BYTE_CTRL_HI = 4'd11;

    localparam logic CMD_REG_WRITE = 1'b0;
    localparam logic CMD_READ_DATA = 1'b1;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_FIFO_A = 2'd2;
    localparam logic [1:0] KIND_FIFO_B = 2'd3;

    localparam logic [1:0] STEP_INC0  = 2'd0;
    localparam logic [1:0] STEP_DEC   = 2'd1;
    localparam logic [1:0] STEP_FIXED = 2'd2;
    localparam logic [1:0] STEP_INC3  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  reg_offset;
        logic [7:0]  wr_byte;
        logic [31:0] read_data;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mem_address;
        logic        is_word;
        logic [31:0] write_data;
        logic        last;
    } req_item_t;

    typedef logic [CHAN_BYTES-1:0][7:0] chan_bytes_t;

    typedef logic [$clog2(REQ_QUEUE_DEPTH)-1:0] qptr_t;
    typedef logic [$clog2(REQ_QUEUE_DEPTH):0]   qcount_t;

endpackage : dma4_pkg
`default_nettype wire

// ----- hdl/four_channel_dma_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_dma_engine
// register-file driven dma engine with four channels, one run at a time
// ----------------------------------------------------------------------------
// cmd channel: a transaction is either a processor byte write into the 48-byte
// register file (source, destination, count, control per channel) or the read
// data returned by memory for the pending read request.
// req channel: read requests, write requests and sound fifo feeds.
// a byte write that starts a run gives one read request; each read data
// transaction gives a write request and, while transfers remain, the next
// read request. a destination at a sound fifo port gives one feed instead.
// every transaction is handled in the cycle it is accepted; its requests
// enter a four-entry registered output queue and leave one per cycle while
// req_stall is low, so none is visible before the cycle after acceptance. a
// transaction that makes one request can be taken every cycle while req_stall
// is low; two requests per transaction cannot keep that rate, a limit set by
// the single output port of the queue. cmd_stall rises when fewer than two
// queue entries are free, so a stalled receiver backs up into the cmd channel
// without loss. reset clears the register file, the run state and the queue.
// ----------------------------------------------------------------------------
module four_channel_dma_engine
    import dma4_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd_data,
    output logic           req_valid,
    input  wire logic      req_stall,
    output req_item_t      req_data
);

    chan_bytes_t regs_reg  [NUM_CHANNELS];
    chan_bytes_t regs_next [NUM_CHANNELS];
    logic        busy_reg,    busy_next;
    logic [1:0]  active_reg,  active_next;
    logic [31:0] src_reg,     src_next;
    logic [31:0] dst_reg,     dst_next;
    logic [16:0] remain_reg,  remain_next;
    logic        word_reg,    word_next;
    logic [1:0]  sstep_reg,   sstep_next;
    logic [1:0]  dstep_reg,   dstep_next;

    req_item_t   queue_reg [REQ_QUEUE_DEPTH];
    qptr_t       head_reg,  head_next;
    qptr_t       tail_reg,  tail_next;
    qcount_t     count_reg, count_next;

    logic        accept;
    logic        pop;
    logic        push0;
    logic        push1;
    req_item_t   res0;
    req_item_t   res1;

    logic [1:0]  in_ch;
    logic [5:0]  ch_base;
    logic [5:0]  byte_off;
    logic [3:0]  byte_idx;
    logic        in_range;
    chan_bytes_t sel;
    logic [31:0] src_m;
    logic [31:0] dst_m;
    logic [15:0] cnt_raw;
    logic [16:0] cnt_run;
    logic        fin;
    logic [31:0] src_adv;
    logic [31:0] dst_adv;

    function automatic logic [31:0] advance(input logic [31:0] addr,
                                            input logic [1:0]  code,
                                            input logic        word);
        logic [31:0] delta;
        delta = word ? 32'd4 : 32'd2;
        case (code)
            STEP_DEC:   advance = addr - delta;
            STEP_FIXED: advance = addr;
            default:    advance = addr + delta;
        endcase
    endfunction

    assign accept    = cmd_valid && !cmd_stall;
    assign pop       = req_valid && !req_stall;
    assign cmd_stall = (count_reg > qcount_t'(REQ_QUEUE_DEPTH - 2));
    assign req_valid = (count_reg != '0);
    assign req_data  = queue_reg[head_reg];

    // offset decode
    always_comb
    begin
        if (cmd_data.reg_offset < 6'd12)
        begin
            in_ch   = 2'd0;
            ch_base = 6'd0;
        end
        else if (cmd_data.reg_offset < 6'd24)
        begin
            in_ch   = 2'd1;
            ch_base = 6'd12;
        end
        else if (cmd_data.reg_offset < 6'd36)
        begin
            in_ch   = 2'd2;
            ch_base = 6'd24;
        end
        else
        begin
            in_ch   = 2'd3;
            ch_base = 6'd36;
        end
        byte_off = cmd_data.reg_offset - ch_base;
        byte_idx = byte_off[3:0];
        in_range = (cmd_data.reg_offset < 6'(FILE_BYTES));
    end

    // channel fields for a run start, end test and next addresses of the active run
    always_comb
    begin
        sel     = regs_reg[in_ch];
        src_m   = {sel[3], sel[2], sel[1], sel[0]} & ADDR_MASK;
        dst_m   = {sel[7], sel[6], sel[5], sel[4]} & ADDR_MASK;
        cnt_raw = {sel[BYTE_CNT_HI], sel[BYTE_CNT_LO]};
        if (in_ch == 2'd3)
        begin
            cnt_run = (cnt_raw == 16'd0) ? CNT_FULL_CH3 : {1'b0, cnt_raw};
        end
        else
        begin
            cnt_run = ((cnt_raw[13:0] & CNT_MASK) == 14'd0) ? CNT_FULL
                                                            : {3'b000, cnt_raw[13:0]};
        end
        fin     = (remain_reg <= 17'd1);
        src_adv = advance(src_reg, sstep_reg, word_reg);
        dst_adv = advance(dst_reg, dstep_reg, word_reg);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            regs_next[i] = regs_reg[i];
        end
        busy_next   = busy_reg;
        active_next = active_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        remain_next = remain_reg;
        word_next   = word_reg;
        sstep_next  = sstep_reg;
        dstep_next  = dstep_reg;
        push0       = 1'b0;
        push1       = 1'b0;
        res0        = '0;
        res1        = '0;

        if (accept)
        begin
            if (cmd_data.cmd == CMD_REG_WRITE)
            begin
                if (in_range)
                begin
                    if (byte_idx != BYTE_CTRL_HI || !cmd_data.wr_byte[7])
                    begin
                        regs_next[in_ch][byte_idx] = cmd_data.wr_byte;
                    end
                    else if (busy_reg)
                    begin
                        regs_next[in_ch][byte_idx] = {1'b0, cmd_data.wr_byte[6:0]};
                    end
                    else if (dst_m == FIFO_A_ADDR || dst_m == FIFO_B_ADDR)
                    begin
                        regs_next[in_ch][byte_idx] = {1'b0, cmd_data.wr_byte[6:0]};
                        push0            = 1'b1;
                        res0.kind        = (dst_m == FIFO_A_ADDR) ? KIND_FIFO_A
                                                                  : KIND_FIFO_B;
                        res0.mem_address = src_m;
                        res0.last        = 1'b1;
                    end
                    else
                    begin
                        regs_next[in_ch][byte_idx] = cmd_data.wr_byte;
                        busy_next   = 1'b1;
                        active_next = in_ch;
                        src_next    = src_m;
                        dst_next    = dst_m;
                        remain_next = cnt_run;
                        word_next   = cmd_data.wr_byte[2];
                        sstep_next  = {cmd_data.wr_byte[0], sel[BYTE_CTRL_LO][7]};
                        dstep_next  = sel[BYTE_CTRL_LO][6:5];
                        push0            = 1'b1;
                        res0.kind        = KIND_READ;
                        res0.mem_address = src_m;
                        res0.is_word     = cmd_data.wr_byte[2];
                    end
                end
            end
            else if (busy_reg)
            begin
                push0            = 1'b1;
                res0.kind        = KIND_WRITE;
                res0.mem_address = dst_reg;
                res0.is_word     = word_reg;
                res0.write_data  = word_reg ? cmd_data.read_data
                                            : {16'h0000, cmd_data.read_data[15:0]};
                res0.last        = fin;
                src_next         = src_adv;
                dst_next         = dst_adv;
                if (fin)
                begin
                    remain_next = '0;
                    busy_next   = 1'b0;
                    regs_next[active_reg][BYTE_CTRL_HI][7] = 1'b0;
                end
                else
                begin
                    remain_next      = remain_reg - 17'd1;
                    push1            = 1'b1;
                    res1.kind        = KIND_READ;
                    res1.mem_address = src_adv;
                    res1.is_word     = word_reg;
                end
            end
        end
    end

    // output queue pointers and fill count
    always_comb
    begin
        head_next  = pop ? head_reg + qptr_t'(1) : head_reg;
        tail_next  = tail_reg + qptr_t'(push0) + qptr_t'(push1);
        count_next = count_reg + qcount_t'(push0) + qcount_t'(push1) - qcount_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                regs_reg[i] <= '0;
            end
            busy_reg   <= 1'b0;
            active_reg <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            remain_reg <= '0;
            word_reg   <= 1'b0;
            sstep_reg  <= '0;
            dstep_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                regs_reg[i] <= regs_next[i];
            end
            busy_reg   <= busy_next;
            active_reg <= active_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            remain_reg <= remain_next;
            word_reg   <= word_next;
            sstep_reg  <= sstep_next;
            dstep_reg  <= dstep_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
        end
    end

    // queue entries
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            queue_reg[tail_reg] <= res0;
        end
        if (push1)
        begin
            queue_reg[tail_reg + qptr_t'(1)] <= res1;
        end
    end

endmodule : four_channel_dma_engine
`default_nettype wire

// ----- verif/dma_request_checker.sv -----
// ----------------------------------------------------------------------------
// dma_request_checker
// watches both channels of the four-channel dma engine, keeps its own model of
// the register file and the active run, predicts the read, write and sound
// fifo requests of every accepted transaction and compares each accepted
// request field by field with the oldest prediction
// ----------------------------------------------------------------------------
module dma_request_checker
    import dma4_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    input  wire logic      cmd_stall,
    input  wire cmd_item_t cmd_data,
    input  wire logic      req_valid,
    input  wire logic      req_stall,
    input  wire req_item_t req_data,
    output int             expected_left,
    output int             mismatch_total
);

    logic [7:0]  reg_file [FILE_BYTES];
    req_item_t   expected_reqs [$];
    logic        busy;
    logic [1:0]  run_channel;
    logic [31:0] run_src;
    logic [31:0] run_dst;
    logic [16:0] run_left;
    logic        run_word;
    logic [1:0]  src_mode;
    logic [1:0]  dst_mode;
    int          errors_seen;

    function automatic logic [31:0] file_word(input int unsigned at);
        return {reg_file[at + 3], reg_file[at + 2], reg_file[at + 1], reg_file[at]};
    endfunction

    function automatic logic [31:0] next_address(input logic [31:0] addr,
                                                 input logic [1:0] code);
        logic [31:0] delta;
        delta = run_word ? 32'd4 : 32'd2;
        case (code)
            STEP_DEC:   return addr - delta;
            STEP_FIXED: return addr;
            default:    return addr + delta;
        endcase
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic add_expected(input req_item_t r);
        expected_reqs.insert(expected_reqs.size(), r);
    endtask

    task automatic compare_request(input req_item_t got);
        req_item_t want;
        int        bad;
        if (expected_reqs.size() == 0)
        begin
            $display("%0t: request expected none got %h", $time, got);
            errors_seen++;
            return;
        end
        want = expected_reqs.pop_front();
        bad = 0;
        bad += int'(field_differs("kind", 32'(want.kind), 32'(got.kind)));
        bad += int'(field_differs("mem_address", want.mem_address, got.mem_address));
        bad += int'(field_differs("is_word", 32'(want.is_word), 32'(got.is_word)));
        bad += int'(field_differs("write_data", want.write_data, got.write_data));
        bad += int'(field_differs("last", 32'(want.last), 32'(got.last)));
        if (bad != 0)
            errors_seen++;
    endtask

    task automatic predict_requests(input cmd_item_t it);
        int unsigned off;
        int unsigned ch;
        int unsigned base;
        int unsigned ctrl_at;
        logic [31:0] src;
        logic [31:0] dst;
        logic [16:0] count;
        logic [15:0] ctrl;
        logic        fin;
        req_item_t   r;
        off = 32'(it.reg_offset);
        if (it.cmd == CMD_REG_WRITE)
        begin
            if (off >= FILE_BYTES)
                return;
            if (off % CHAN_BYTES != BYTE_CTRL_HI || !it.wr_byte[7])
            begin
                reg_file[off] = it.wr_byte;
                return;
            end
            if (busy)
            begin
                reg_file[off] = {1'b0, it.wr_byte[6:0]};
                return;
            end
            ch = off / CHAN_BYTES;
            base = ch * CHAN_BYTES;
            src = file_word(base) & ADDR_MASK;
            dst = file_word(base + 4) & ADDR_MASK;
            count = {1'b0, reg_file[base + BYTE_CNT_HI], reg_file[base + BYTE_CNT_LO]};
            if (ch == NUM_CHANNELS - 1)
            begin
                if (count == '0)
                    count = CNT_FULL_CH3;
            end
            else
            begin
                count = count & {3'b0, CNT_MASK};
                if (count == '0)
                    count = CNT_FULL;
            end
            ctrl = {it.wr_byte, reg_file[base + BYTE_CTRL_LO]};
            if (dst == FIFO_A_ADDR || dst == FIFO_B_ADDR)
            begin
                reg_file[off] = {1'b0, it.wr_byte[6:0]};
                r.kind = (dst == FIFO_A_ADDR) ? KIND_FIFO_A : KIND_FIFO_B;
                r.mem_address = src;
                r.is_word = 1'b0;
                r.write_data = '0;
                r.last = 1'b1;
                add_expected(r);
                return;
            end
            reg_file[off] = it.wr_byte;
            busy = 1'b1;
            run_channel = ch[1:0];
            run_src = src;
            run_dst = dst;
            run_left = count;
            run_word = ctrl[10];
            src_mode = ctrl[8:7];
            dst_mode = ctrl[6:5];
            r.kind = KIND_READ;
            r.mem_address = run_src;
            r.is_word = run_word;
            r.write_data = '0;
            r.last = 1'b0;
            add_expected(r);
            return;
        end
        if (!busy)
            return;
        fin = (run_left <= 17'd1);
        r.kind = KIND_WRITE;
        r.mem_address = run_dst;
        r.is_word = run_word;
        r.write_data = run_word ? it.read_data : {16'h0, it.read_data[15:0]};
        r.last = fin;
        add_expected(r);
        run_src = next_address(run_src, src_mode);
        run_dst = next_address(run_dst, dst_mode);
        run_left = run_left - 1'b1;
        if (fin)
        begin
            ctrl_at = run_channel * CHAN_BYTES + BYTE_CTRL_HI;
            run_left = '0;
            busy = 1'b0;
            reg_file[ctrl_at][7] = 1'b0;
            return;
        end
        r.kind = KIND_READ;
        r.mem_address = run_src;
        r.is_word = run_word;
        r.write_data = '0;
        r.last = 1'b0;
        add_expected(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILE_BYTES; i++)
                reg_file[i] = '0;
            busy = 1'b0;
            run_channel = '0;
            run_src = '0;
            run_dst = '0;
            run_left = '0;
            run_word = 1'b0;
            src_mode = STEP_INC0;
            dst_mode = STEP_INC0;
            errors_seen = 0;
            expected_reqs.delete();
            expected_left <= 0;
            mismatch_total <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                compare_request(req_data);
            if (cmd_valid && !cmd_stall)
                predict_requests(cmd_data);
            expected_left <= expected_reqs.size();
            mismatch_total <= errors_seen;
        end
    end

endmodule : dma_request_checker

// ----- verif/four_channel_dma_engine_tb.sv -----
// ----------------------------------------------------------------------------
// four_channel_dma_engine_tb
// drives register byte writes and read data returns into the dma engine:
// directed runs on every channel, step code, transfer size and sound fifo
// destination, random runs mixed with stray traffic, then a full-length
// count run; both sides idle at random and a separate checker judges requests
// ----------------------------------------------------------------------------
module four_channel_dma_engine_tb;
    import dma4_pkg::*;

    localparam int IDLE_PCT     = 13;
    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 800;
    localparam int unsigned ALL_TRANSFERS = 32'hFFFF_FFFF;
    localparam int unsigned FEW_TRANSFERS = 4;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_item_t   cmd_data = '0;
    logic        req_valid;
    logic        req_stall = 1'b0;
    req_item_t   req_data;
    int          expected_left;
    int          mismatch_total;
    bit          idling = 1'b1;
    int unsigned items_sent = 0;
    int          quiet_cycles = 0;

    four_channel_dma_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data)
    );

    dma_request_checker request_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_data       (cmd_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .expected_left  (expected_left),
        .mismatch_total (mismatch_total)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
        req_stall <= idling && ($urandom_range(99) < IDLE_PCT);

    // ends the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("four_channel_dma_engine_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic issue_cmd(input cmd_item_t it);
        while (idling && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input int unsigned off, input logic [7:0] value);
        cmd_item_t it;
        it.cmd = CMD_REG_WRITE;
        it.reg_offset = off[5:0];
        it.wr_byte = value;
        it.read_data = $urandom;
        issue_cmd(it);
    endtask

    task automatic return_data(input logic [31:0] value);
        cmd_item_t it;
        it.cmd = CMD_READ_DATA;
        it.reg_offset = 6'($urandom_range(63));
        it.wr_byte = 8'($urandom_range(255));
        it.read_data = value;
        issue_cmd(it);
    endtask

    task automatic wait_for_requests();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] ctrl_word(input logic word, input logic [1:0] s_step,
                                              input logic [1:0] d_step);
        return {5'b0, word, 1'b0, s_step, d_step, 5'b0};
    endfunction

    function automatic int unsigned transfer_count(input int unsigned ch,
                                                   input logic [15:0] count);
        if (ch == NUM_CHANNELS - 1)
            return (count == '0) ? 32'(CNT_FULL_CH3) : 32'(count);
        return (count[13:0] == '0) ? 32'(CNT_FULL) : 32'(count[13:0]);
    endfunction

    // sets up and starts a channel, feeds one read data per transfer up to max_feed
    task automatic start_run(input int unsigned ch, input logic [31:0] src,
                             input logic [31:0] dst, input logic [15:0] count,
                             input logic [15:0] ctrl, input bit noisy,
                             input int unsigned max_feed);
        int unsigned base;
        int unsigned len;
        logic [31:0] masked;
        base = ch * CHAN_BYTES;
        masked = dst & ADDR_MASK;
        if ($urandom_range(9) != 0)
        begin
            for (int i = 0; i < 4; i++)
                write_reg(base + i, src[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++)
            write_reg(base + 4 + i, dst[8*i +: 8]);
        write_reg(base + BYTE_CNT_LO, count[7:0]);
        write_reg(base + BYTE_CNT_HI, count[15:8]);
        write_reg(base + BYTE_CTRL_LO, ctrl[7:0]);
        write_reg(base + BYTE_CTRL_HI, ctrl[15:8] | 8'h80);
        if (masked == FIFO_A_ADDR || masked == FIFO_B_ADDR)
            return;
        len = transfer_count(ch, count);
        if (len > max_feed)
            len = max_feed;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noisy && i == 0)
            begin
                write_reg(base + $urandom_range(10), 8'($urandom_range(255)));
                write_reg(((ch + 1) % NUM_CHANNELS) * CHAN_BYTES + BYTE_CTRL_HI, 8'hFF);
            end
            else if (noisy && $urandom_range(9) == 0)
                write_reg($urandom_range(63), 8'($urandom_range(255)));
            return_data($urandom);
        end
    endtask

    initial
    begin
        bit drained;
        drained = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        return_data(32'hFFFF_FFFF);
        return_data(32'h0000_0000);
        write_reg(63, 8'hFF);
        write_reg(59, 8'h80);
        write_reg(48, 8'h00);
        start_run(0, 32'hFFFF_FFFE, 32'h1234_5678, 16'hC002,
                  ctrl_word(1'b1, STEP_INC0, STEP_DEC), 1'b0, ALL_TRANSFERS);
        start_run(1, 32'h0000_0000, 32'hF000_0000, 16'h0003,
                  ctrl_word(1'b0, STEP_FIXED, STEP_INC3), 1'b0, ALL_TRANSFERS);
        start_run(2, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0002,
                  ctrl_word(1'b0, STEP_DEC, STEP_FIXED), 1'b1, ALL_TRANSFERS);
        start_run(3, 32'h0FFF_FFFD, 32'h0000_0002, 16'h0001,
                  ctrl_word(1'b1, STEP_INC3, STEP_DEC), 1'b0, ALL_TRANSFERS);
        start_run(1, 32'hABCD_0123, FIFO_A_ADDR | 32'hF000_0000, 16'h0005,
                  ctrl_word(1'b1, STEP_INC0, STEP_INC0), 1'b0, ALL_TRANSFERS);
        start_run(2, 32'h1111_2222, FIFO_B_ADDR, 16'h0000,
                  ctrl_word(1'b0, STEP_DEC, STEP_FIXED), 1'b0, ALL_TRANSFERS);
        return_data(32'h5A5A_A5A5);

        while (items_sent < RANDOM_ITEMS)
        begin
            int unsigned ch;
            int unsigned pick;
            logic [31:0] src;
            logic [31:0] dst;
            logic [15:0] count;
            int unsigned off;
            logic [7:0]  value;
            idling = !(items_sent >= 250 && items_sent < 400);
            if (!drained && items_sent >= 500)
            begin
                wait_for_requests();
                drained = 1'b1;
            end
            if ($urandom_range(99) < 75)
            begin
                ch = $urandom_range(NUM_CHANNELS - 1);
                pick = $urandom_range(9);
                src = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                pick = $urandom_range(19);
                case (pick)
                    0:       dst = FIFO_A_ADDR | ($urandom_range(15) << 28);
                    1:       dst = FIFO_B_ADDR | ($urandom_range(15) << 28);
                    2:       dst = 32'h0;
                    3:       dst = 32'hFFFF_FFFF;
                    default: dst = $urandom;
                endcase
                count = ($urandom_range(19) == 0) ? 16'($urandom_range(9, 40))
                                                  : 16'($urandom_range(1, 6));
                if (ch != NUM_CHANNELS - 1)
                    count[15:14] = 2'($urandom_range(3));
                start_run(ch, src, dst, count, 16'($urandom_range(16'hFFFF)),
                          $urandom_range(4) == 0, ALL_TRANSFERS);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(1) == 0)
                        return_data($urandom);
                    else
                    begin
                        off = $urandom_range(63);
                        value = 8'($urandom_range(255));
                        // idle engine: keep stray control writes from starting a run
                        if (off < FILE_BYTES && off % CHAN_BYTES == BYTE_CTRL_HI)
                            value[7] = 1'b0;
                        write_reg(off, value);
                    end
                end
            end
        end

        wait_for_requests();
        // zero count on channel 3: only the first transfers of the long run
        start_run(3, 32'hFFFF_FFFF, 32'h0FFF_FFF0, 16'h0000,
                  ctrl_word(1'b1, STEP_DEC, STEP_INC3), 1'b0, FEW_TRANSFERS);
        wait_for_requests();
        repeat (10) @(posedge clk);
        if (mismatch_total == 0 && expected_left == 0)
            $display("four_channel_dma_engine_tb: done, clean");
        else
            $display("four_channel_dma_engine_tb: done, errors");
        $finish;
    end

endmodule : four_channel_dma_engine_tb
